### hw/rtl/lccl_pkg.sv
// Shared constants, controller states and control/status bundles for the chunk cache lookup.
`timescale 1ns / 1ps
`default_nettype none
package lccl_pkg;

  // Field and storage widths
  localparam int KEY_W          = 32;
  localparam int STAMP_W        = 64;
  localparam int SLOT_W         = 4;
  localparam int CACHE_SLOTS_DEF = 16;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_DECIDE,
    ST_SCAN,
    ST_SCAN_END,
    ST_COMMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture the requested key
    logic compare;     // register the parallel key match vector
    logic decide;      // register the matching slot number
    logic scan_start;  // clear the stamp scan address
    logic scan_issue;  // read one stamp for the oldest-slot search
    logic commit;      // write key/stamp, advance tick, present result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hit;        // some filled slot holds the key
    logic full;       // every slot was filled at compare time
    logic scan_last;  // the last stamp address is being read
  } status_t;

endpackage
`default_nettype wire

### hw/rtl/lccl_ctrl.sv
// Controller state machine that sequences compare, decide, stamp scan and commit.
`timescale 1ns / 1ps
`default_nettype none
module lccl_ctrl
  import lccl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_COMPARE;
      end
      ST_COMPARE: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (status.hit || !status.full) state_next = ST_COMMIT;
        else                            state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_last) state_next = ST_SCAN_END;
      end
      ST_SCAN_END: state_next = ST_COMMIT;
      ST_COMMIT:   state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_COMPARE: cmd.compare = 1'b1;
      ST_DECIDE: begin
        cmd.decide     = 1'b1;
        cmd.scan_start = 1'b1;
      end
      ST_SCAN:   cmd.scan_issue = 1'b1;
      ST_COMMIT: cmd.commit = 1'b1;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/lccl_dp.sv
// Datapath: key registers, stamp memory, use tick, fill count and result registers.
`timescale 1ns / 1ps
`default_nettype none
module lccl_dp
  import lccl_pkg::*;
#(
  parameter int CACHE_SLOTS = CACHE_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  input  wire logic [KEY_W-1:0]    chunk_key,
  output status_t                  status,
  output logic                     done,
  output logic [SLOT_W-1:0]        slot_index,
  output logic                     hit,
  output logic                     replaced
);

  localparam int IDX_W  = $clog2(CACHE_SLOTS);
  localparam int FILL_W = $clog2(CACHE_SLOTS + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(CACHE_SLOTS - 1);
  localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(CACHE_SLOTS);

  logic [KEY_W-1:0]       slot_keys [CACHE_SLOTS];
  logic [STAMP_W-1:0]     slot_stamps [CACHE_SLOTS];
  logic [KEY_W-1:0]       key_reg;
  logic [CACHE_SLOTS-1:0] match_vec;
  logic                   full;
  logic [FILL_W-1:0]      fill_count;
  logic [STAMP_W-1:0]     use_tick;
  logic [IDX_W-1:0]       hit_idx, hit_idx_next;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       rd_idx;
  logic                   rd_valid;
  logic [STAMP_W-1:0]     rd_data;
  logic [STAMP_W-1:0]     best_stamp;
  logic [IDX_W-1:0]       best_idx;
  logic                   any_match;
  logic [IDX_W-1:0]       slot_sel;
  logic [STAMP_W-1:0]     tick_inc;
  logic [IDX_W+SLOT_W-1:0] slot_wide;

  assign any_match = |match_vec;
  assign tick_inc  = use_tick + STAMP_W'(1);

  assign status.hit       = any_match;
  assign status.full      = full;
  assign status.scan_last = (rd_addr == LAST_IDX);

  // Request key capture
  always_ff @(posedge clk) begin
    if (cmd.load) key_reg <= chunk_key;
  end

  // Parallel key compare over the filled slots
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        match_vec[i] <= (FILL_W'(i) < fill_count) && (slot_keys[i] == key_reg);
      end
      full <= (fill_count == FULL_CNT);
    end
  end

  // Lowest matching slot wins
  always_comb begin
    hit_idx_next = '0;
    for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
      if (match_vec[i]) hit_idx_next = IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) hit_idx <= hit_idx_next;
  end

  // Stamp scan address and read-valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_issue;
    end
    if (cmd.scan_start) begin
      rd_addr <= '0;
    end else if (cmd.scan_issue && (rd_addr != LAST_IDX)) begin
      rd_addr <= rd_addr + IDX_W'(1);
    end
    rd_idx <= rd_addr;
  end

  // Stamp memory: one read port for the scan, one write port at commit
  always_ff @(posedge clk) begin
    if (cmd.scan_issue) rd_data <= slot_stamps[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) slot_stamps[slot_sel] <= tick_inc;
  end

  // Running minimum; strict less keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      if ((rd_idx == '0) || (rd_data < best_stamp)) begin
        best_stamp <= rd_data;
        best_idx   <= rd_idx;
      end
    end
  end

  // Target slot for this request
  always_comb begin
    if (any_match)  slot_sel = hit_idx;
    else if (!full) slot_sel = fill_count[IDX_W-1:0];
    else            slot_sel = best_idx;
  end

  // Key store update
  always_ff @(posedge clk) begin
    if (cmd.commit && !any_match) slot_keys[slot_sel] <= key_reg;
  end

  // Tick and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      use_tick   <= '0;
      fill_count <= '0;
    end else if (cmd.commit) begin
      use_tick <= tick_inc;
      if (!any_match && !full) fill_count <= fill_count + FILL_W'(1);
    end
  end

  // Result word
  assign slot_wide = {{SLOT_W{1'b0}}, slot_sel};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
    end
    if (cmd.commit) begin
      slot_index <= slot_wide[SLOT_W-1:0];
      hit        <= any_match;
      replaced   <= !any_match && full;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lru_chunk_cache_lookup.sv
// Top level of the fully associative LRU chunk cache directory.
//
// Usage: present chunk_key with start high while busy is low; the word is
// taken at that clock edge and busy rises in the next cycle. One result
// word (slot_index, hit, replaced) appears for exactly one cycle with done
// high; the receiver must take it then, it cannot hold it off.
// Steps from the accepting edge to the done word: compare, decide and
// commit for a hit or a miss while slots remain unfilled; compare,
// decide, stamp scan, scan end and commit for a miss with every slot
// filled. A new word can be started in the cycle in which done is high.
// An evicting request runs the oldest-stamp search, which reads the
// stamp memory one slot per cycle and folds in the last read in the
// scan-end state. Keys are compared against all filled slots in parallel.
// Synchronous reset empties the directory (fill count and use tick to
// zero) and returns the controller to idle; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module lru_chunk_cache_lookup
  import lccl_pkg::*;
#(
  parameter int CACHE_SLOTS = CACHE_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [KEY_W-1:0]  chunk_key,
  output logic                   done,
  output logic [SLOT_W-1:0]      slot_index,
  output logic                   hit,
  output logic                   replaced
);

  cmd_t    cmd;
  status_t status;

  lccl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  lccl_dp #(
    .CACHE_SLOTS (CACHE_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .chunk_key  (chunk_key),
    .status     (status),
    .done       (done),
    .slot_index (slot_index),
    .hit        (hit),
    .replaced   (replaced)
  );

endmodule
`default_nettype wire

### tb/sv/lru_lookup_watch.sv
// Lookup watcher: predicts slot/hit/replaced for every accepted key and checks each done word.
`timescale 1ns / 1ps
module lru_lookup_watch
  import lccl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [KEY_W-1:0]  chunk_key,
  input  wire logic              done,
  input  wire logic [SLOT_W-1:0] slot_index,
  input  wire logic              hit,
  input  wire logic              replaced,
  output int                     pending,
  output int                     fail_count
);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              replaced;
  } lookup_word_t;

  // Directory mirror
  logic [KEY_W-1:0]   key_tab   [CACHE_SLOTS_DEF];
  logic [STAMP_W-1:0] stamp_tab [CACHE_SLOTS_DEF];
  int                 fill_cnt;
  logic [STAMP_W-1:0] use_tick;

  lookup_word_t want_q [$];
  lookup_word_t want;

  initial fail_count = 0;

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("%0t ns lookup mismatch: %s", $time, msg);
  endtask

  // Search, then allocate or evict the oldest stamp (lowest index on a tie)
  function automatic lookup_word_t lookup_predict(input logic [KEY_W-1:0] key);
    lookup_word_t w;
    int           idx;
    logic         found;
    idx = 0;
    found = 1'b0;
    w.replaced = 1'b0;
    for (int i = 0; i < fill_cnt; i++) begin
      if (!found && key_tab[i] == key) begin
        idx = i;
        found = 1'b1;
      end
    end
    use_tick = use_tick + 1'b1;
    if (!found) begin
      if (fill_cnt < CACHE_SLOTS_DEF) begin
        idx = fill_cnt;
        fill_cnt++;
      end else begin
        idx = 0;
        for (int i = 1; i < CACHE_SLOTS_DEF; i++)
          if (stamp_tab[i] < stamp_tab[idx]) idx = i;
        w.replaced = 1'b1;
      end
      key_tab[idx] = key;
    end
    stamp_tab[idx] = use_tick;
    w.slot = idx[SLOT_W-1:0];
    w.hit  = found;
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      want_q.delete();
      fill_cnt = 0;
      use_tick = '0;
    end else begin
      // accepted request word
      if (start && !busy) want_q.push_back(lookup_predict(chunk_key));
      // result word, checked against the oldest prediction
      if (done) begin
        if (want_q.size() == 0) begin
          report("result word with nothing pending");
        end else begin
          want = want_q.pop_front();
          if (slot_index !== want.slot)
            report($sformatf("slot_index got %0d want %0d", slot_index, want.slot));
          if (hit !== want.hit)
            report($sformatf("hit got %b want %b", hit, want.hit));
          if (replaced !== want.replaced)
            report($sformatf("replaced got %b want %b", replaced, want.replaced));
        end
      end
    end
    pending <= want_q.size();
  end

endmodule

### tb/sv/tb.sv
// Testbench top: clock, reset, key stimulus with idle phases, and the final verdict.
`timescale 1ns / 1ps
module tb;
  import lccl_pkg::*;

  localparam int RUN_LIMIT = 400000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [KEY_W-1:0]  chunk_key;
  logic              done;
  logic [SLOT_W-1:0] slot_index;
  logic              hit;
  logic              replaced;
  int                pending;
  int                fail_count;
  int                cycle_cnt;

  logic [KEY_W-1:0] key_pool [40];

  // Edge cases first: hit while filling, fill to full, hits on full, evictions
  logic [KEY_W-1:0] directed_keys [24] = '{
    32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
    32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001,
    32'hFFFF_FFFE, 32'h1234_5678, 32'h8765_4321, 32'h0000_FFFF,
    32'hFFFF_0000, 32'h00FF_00FF, 32'hFF00_FF00, 32'h0F0F_0F0F,
    32'hF0F0_F0F0, 32'h0000_0000, 32'h8000_0000, 32'h3333_3333,
    32'hCCCC_CCCC, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h3333_3333
  };

  int idle_pct [4] = '{0, 64, 0, 30};
  int pool_size [4] = '{10, 17, 24, 40};

  lru_chunk_cache_lookup u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .chunk_key  (chunk_key),
    .done       (done),
    .slot_index (slot_index),
    .hit        (hit),
    .replaced   (replaced)
  );

  lru_lookup_watch u_watch (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .chunk_key  (chunk_key),
    .done       (done),
    .slot_index (slot_index),
    .hit        (hit),
    .replaced   (replaced),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Random idle gap before a word, capped
  function automatic int pick_gap(input int pct);
    int g;
    g = 0;
    while (g < 40 && $urandom_range(99) < pct) g++;
    return g;
  endfunction

  // Present one word after a gap and hold it until taken
  task automatic send_word(input logic [KEY_W-1:0] key, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start     <= 1'b1;
    chunk_key <= key;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    logic [KEY_W-1:0] key;
    rst       = 1'b1;
    start     = 1'b0;
    chunk_key = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_keys[i]) send_word(directed_keys[i], 0);

    // Random phases: pool size sets the hit/evict mix, mostly pooled keys
    for (int ph = 0; ph < 4; ph++) begin
      foreach (key_pool[i]) key_pool[i] = $urandom;
      for (int n = 0; n < 500; n++) begin
        if ($urandom_range(9) == 0) key = $urandom;
        else key = key_pool[$urandom_range(pool_size[ph] - 1)];
        send_word(key, (n % 100 < 20) ? 0 : pick_gap(idle_pct[ph]));
      end
    end
    @(negedge clk);
    start <= 1'b0;

    // Drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (CACHE_SLOTS_DEF + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### lru_chunk_cache_lookup.f
hw/rtl/lccl_pkg.sv
hw/rtl/lccl_ctrl.sv
hw/rtl/lccl_dp.sv
hw/rtl/lru_chunk_cache_lookup.sv
tb/sv/lru_lookup_watch.sv
tb/sv/tb.sv
